[design/at_command_line_receiver_core_macros.svh]
// Assertion macros for the AT command line receiver checker.
// Used by atclr_checker.sv; no other dependencies.
`ifndef AT_COMMAND_LINE_RECEIVER_CORE_MACROS_SVH
`define AT_COMMAND_LINE_RECEIVER_CORE_MACROS_SVH

// Generic clocked property, off while reset is asserted.
`define ATCLR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds its value in the cycle after a condition.
`define ATCLR_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[design/atclr_pkg.sv]
// Shared types and constants for the AT command line receiver.
// No dependencies; used by atclr_ctrl, atclr_dp, the top level and the checker.
`default_nettype none

package atclr_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LEN_W      = LINE_AW;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_UT  = 8'h54;
  localparam logic [7:0] CH_LT  = 8'h74;

  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CLS_CR,
    CLS_LF,
    CLS_ERASE,
    CLS_A,
    CLS_T,
    CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STORE_T,
    S_ECHO_A,
    S_ECHO_T,
    S_ECHO_LAST,
    S_ECHO_THEN_REJ,
    S_ECHO_THEN_CMD,
    S_ERASE_BS1,
    S_ERASE_SP,
    S_ERASE_BS2,
    S_REJECT,
    S_PREFETCH,
    S_CMD
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR_PENDING,
    DP_HOLD_A,
    DP_START_LINE,
    DP_STORE_T,
    DP_ERASE,
    DP_STORE,
    DP_OVERFLOW,
    DP_END_DISCARD,
    DP_END_LINE
  } dp_op_t;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_ECHO_HELD,
    OUT_ECHO_BYTE,
    OUT_BS,
    OUT_SP,
    OUT_REJECT,
    OUT_CMD
  } out_op_t;

  typedef struct packed {
    logic    latch;
    dp_op_t  dp_op;
    out_op_t out_op;
    logic    out_last;
    logic    rd_first;
    logic    rd_next;
  } dp_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic echo_en;
    logic active;
    logic discard;
    logic pending;
    logic len_zero;
    logic len_full;
    logic stream_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/atclr_in_if.sv]
// Input channel: one received terminal byte per item.
// Standalone interface; no package dependency.
`default_nettype none

interface atclr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[design/atclr_out_if.sv]
// Result channel: echo bytes, command bytes and rejection events.
// Standalone interface; no package dependency.
`default_nettype none

interface atclr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output result_kind, output out_byte,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[design/atclr_ctrl.sv]
// Controller FSM for the AT command line receiver.
// Depends on atclr_pkg; drives atclr_dp through dp_cmd_t, reads dp_sts_t.
`default_nettype none

module atclr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire atclr_pkg::dp_sts_t sts,
  output atclr_pkg::dp_cmd_t      cmd
);

  atclr_pkg::state_t state_r, state_nxt;
  atclr_pkg::state_t dec_next;
  atclr_pkg::dp_op_t dec_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atclr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decision taken once per item, in the decode cycle.
  always_comb begin
    dec_next = atclr_pkg::S_IDLE;
    dec_op   = atclr_pkg::DP_NOP;
    if (!sts.active) begin
      unique case (sts.cls)
        atclr_pkg::CLS_T: begin
          if (sts.pending) begin
            dec_op   = atclr_pkg::DP_START_LINE;
            dec_next = atclr_pkg::S_STORE_T;
          end else begin
            dec_op = atclr_pkg::DP_CLR_PENDING;
          end
        end
        atclr_pkg::CLS_A: dec_op = atclr_pkg::DP_HOLD_A;
        default:          dec_op = atclr_pkg::DP_CLR_PENDING;
      endcase
    end else begin
      unique case (sts.cls)
        atclr_pkg::CLS_LF: dec_op = atclr_pkg::DP_NOP;
        atclr_pkg::CLS_ERASE: begin
          if (!sts.discard && !sts.len_zero) begin
            dec_op   = atclr_pkg::DP_ERASE;
            dec_next = sts.echo_en ? atclr_pkg::S_ERASE_BS1 : atclr_pkg::S_IDLE;
          end
        end
        atclr_pkg::CLS_CR: begin
          if (sts.discard) begin
            dec_op   = atclr_pkg::DP_END_DISCARD;
            dec_next = sts.echo_en ? atclr_pkg::S_ECHO_LAST : atclr_pkg::S_IDLE;
          end else begin
            dec_next = sts.echo_en ? atclr_pkg::S_ECHO_THEN_CMD : atclr_pkg::S_PREFETCH;
          end
        end
        default: begin
          if (sts.discard) begin
            dec_next = sts.echo_en ? atclr_pkg::S_ECHO_LAST : atclr_pkg::S_IDLE;
          end else if (sts.len_full) begin
            dec_op   = atclr_pkg::DP_OVERFLOW;
            dec_next = sts.echo_en ? atclr_pkg::S_ECHO_THEN_REJ : atclr_pkg::S_REJECT;
          end else begin
            dec_op   = atclr_pkg::DP_STORE;
            dec_next = sts.echo_en ? atclr_pkg::S_ECHO_LAST : atclr_pkg::S_IDLE;
          end
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atclr_pkg::S_IDLE:    if (in_valid) state_nxt = atclr_pkg::S_DECODE;
      atclr_pkg::S_DECODE:  state_nxt = dec_next;
      atclr_pkg::S_STORE_T: begin
        state_nxt = sts.echo_en ? atclr_pkg::S_ECHO_A : atclr_pkg::S_IDLE;
      end
      atclr_pkg::S_ECHO_A:        if (sts.out_free) state_nxt = atclr_pkg::S_ECHO_T;
      atclr_pkg::S_ECHO_T:        if (sts.out_free) state_nxt = atclr_pkg::S_IDLE;
      atclr_pkg::S_ECHO_LAST:     if (sts.out_free) state_nxt = atclr_pkg::S_IDLE;
      atclr_pkg::S_ECHO_THEN_REJ: if (sts.out_free) state_nxt = atclr_pkg::S_REJECT;
      atclr_pkg::S_ECHO_THEN_CMD: if (sts.out_free) state_nxt = atclr_pkg::S_PREFETCH;
      atclr_pkg::S_ERASE_BS1:     if (sts.out_free) state_nxt = atclr_pkg::S_ERASE_SP;
      atclr_pkg::S_ERASE_SP:      if (sts.out_free) state_nxt = atclr_pkg::S_ERASE_BS2;
      atclr_pkg::S_ERASE_BS2:     if (sts.out_free) state_nxt = atclr_pkg::S_IDLE;
      atclr_pkg::S_REJECT:        if (sts.out_free) state_nxt = atclr_pkg::S_IDLE;
      atclr_pkg::S_PREFETCH:      state_nxt = atclr_pkg::S_CMD;
      atclr_pkg::S_CMD: begin
        if (sts.out_free && sts.stream_done) state_nxt = atclr_pkg::S_IDLE;
      end
      default: state_nxt = atclr_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.dp_op    = atclr_pkg::DP_NOP;
    cmd.out_op   = atclr_pkg::OUT_NONE;
    unique case (state_r)
      atclr_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      atclr_pkg::S_DECODE:  cmd.dp_op = dec_op;
      atclr_pkg::S_STORE_T: cmd.dp_op = atclr_pkg::DP_STORE_T;
      atclr_pkg::S_ECHO_A: begin
        if (sts.out_free) cmd.out_op = atclr_pkg::OUT_ECHO_HELD;
      end
      atclr_pkg::S_ECHO_T, atclr_pkg::S_ECHO_LAST: begin
        if (sts.out_free) begin
          cmd.out_op   = atclr_pkg::OUT_ECHO_BYTE;
          cmd.out_last = 1'b1;
        end
      end
      atclr_pkg::S_ECHO_THEN_REJ, atclr_pkg::S_ECHO_THEN_CMD: begin
        if (sts.out_free) cmd.out_op = atclr_pkg::OUT_ECHO_BYTE;
      end
      atclr_pkg::S_ERASE_BS1: begin
        if (sts.out_free) cmd.out_op = atclr_pkg::OUT_BS;
      end
      atclr_pkg::S_ERASE_SP: begin
        if (sts.out_free) cmd.out_op = atclr_pkg::OUT_SP;
      end
      atclr_pkg::S_ERASE_BS2: begin
        if (sts.out_free) begin
          cmd.out_op   = atclr_pkg::OUT_BS;
          cmd.out_last = 1'b1;
        end
      end
      atclr_pkg::S_REJECT: begin
        if (sts.out_free) begin
          cmd.out_op   = atclr_pkg::OUT_REJECT;
          cmd.out_last = 1'b1;
        end
      end
      atclr_pkg::S_PREFETCH: cmd.rd_first = 1'b1;
      atclr_pkg::S_CMD: begin
        if (sts.out_free) begin
          cmd.out_op   = atclr_pkg::OUT_CMD;
          cmd.out_last = sts.stream_done;
          if (sts.stream_done) begin
            cmd.dp_op = atclr_pkg::DP_END_LINE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/atclr_dp.sv]
// Datapath: line state, line memory and result output register.
// Depends on atclr_pkg; commanded by atclr_ctrl.
`default_nettype none

module atclr_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic [7:0]         in_byte,
  input  wire atclr_pkg::dp_cmd_t cmd,
  output atclr_pkg::dp_sts_t      sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_byte,
  output logic                    out_last
);

  localparam logic [atclr_pkg::LEN_W-1:0] LEN_FULL =
    atclr_pkg::LEN_W'(atclr_pkg::LINE_DEPTH - 1);
  localparam logic [atclr_pkg::LEN_W-1:0] LEN_ONE   = atclr_pkg::LEN_W'(1);
  localparam logic [atclr_pkg::LEN_W-1:0] LEN_START = atclr_pkg::LEN_W'(2);

  logic                         echo_en_r;
  logic                         pending_r,  pending_nxt;
  logic [7:0]                   held_a_r,   held_a_nxt;
  logic                         active_r,   active_nxt;
  logic                         discard_r,  discard_nxt;
  logic [atclr_pkg::LEN_W-1:0]  len_r,      len_nxt;
  logic [atclr_pkg::LEN_W-1:0]  idx_r,      idx_nxt;
  logic [7:0]                   byte_r;

  logic [7:0]                   line_mem [atclr_pkg::LINE_DEPTH];
  logic                         mem_we;
  logic [atclr_pkg::LINE_AW-1:0] mem_waddr;
  logic [7:0]                   mem_wdata;
  logic                         mem_re;
  logic [atclr_pkg::LINE_AW-1:0] mem_raddr;
  logic [7:0]                   rdata_r;

  logic                         out_valid_r;
  logic [1:0]                   out_kind_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r;
  atclr_pkg::kind_t             ld_kind;
  logic [7:0]                   ld_byte;

  atclr_pkg::cls_t              cls;

  always_comb begin
    unique case (byte_r) inside
      atclr_pkg::CH_CR:                   cls = atclr_pkg::CLS_CR;
      atclr_pkg::CH_LF:                   cls = atclr_pkg::CLS_LF;
      atclr_pkg::CH_BS, atclr_pkg::CH_DEL: cls = atclr_pkg::CLS_ERASE;
      atclr_pkg::CH_UA, atclr_pkg::CH_LA: cls = atclr_pkg::CLS_A;
      atclr_pkg::CH_UT, atclr_pkg::CH_LT: cls = atclr_pkg::CLS_T;
      default:                            cls = atclr_pkg::CLS_OTHER;
    endcase
  end

  // Line state updates
  always_comb begin
    pending_nxt = pending_r;
    held_a_nxt  = held_a_r;
    active_nxt  = active_r;
    discard_nxt = discard_r;
    len_nxt     = len_r;
    mem_we      = 1'b0;
    mem_waddr   = len_r[atclr_pkg::LINE_AW-1:0];
    mem_wdata   = byte_r;
    unique case (cmd.dp_op)
      atclr_pkg::DP_CLR_PENDING: pending_nxt = 1'b0;
      atclr_pkg::DP_HOLD_A: begin
        held_a_nxt  = byte_r;
        pending_nxt = 1'b1;
      end
      atclr_pkg::DP_START_LINE: begin
        mem_we      = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = held_a_r;
        len_nxt     = LEN_START;
        active_nxt  = 1'b1;
        pending_nxt = 1'b0;
      end
      atclr_pkg::DP_STORE_T: begin
        mem_we    = 1'b1;
        mem_waddr = atclr_pkg::LINE_AW'(1);
      end
      atclr_pkg::DP_ERASE: begin
        len_nxt = len_r - LEN_ONE;
        if (len_r == LEN_ONE) begin
          active_nxt  = 1'b0;
          pending_nxt = 1'b0;
        end
      end
      atclr_pkg::DP_STORE: begin
        mem_we  = 1'b1;
        len_nxt = len_r + LEN_ONE;
      end
      atclr_pkg::DP_OVERFLOW: begin
        len_nxt     = '0;
        discard_nxt = 1'b1;
      end
      atclr_pkg::DP_END_DISCARD: begin
        discard_nxt = 1'b0;
        len_nxt     = '0;
        active_nxt  = 1'b0;
        pending_nxt = 1'b0;
      end
      atclr_pkg::DP_END_LINE: begin
        len_nxt     = '0;
        active_nxt  = 1'b0;
        pending_nxt = 1'b0;
      end
      default: len_nxt = len_r;
    endcase
  end

  // Stream read index: counts entries already fetched
  always_comb begin
    idx_nxt   = idx_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r[atclr_pkg::LINE_AW-1:0];
    if (cmd.rd_first) begin
      mem_re    = 1'b1;
      mem_raddr = '0;
      idx_nxt   = LEN_ONE;
    end else if (cmd.rd_next) begin
      mem_re  = 1'b1;
      idx_nxt = idx_r + LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r <= 1'b1;
      pending_r <= 1'b0;
      held_a_r  <= '0;
      active_r  <= 1'b0;
      discard_r <= 1'b0;
      len_r     <= '0;
      idx_r     <= '0;
    end else begin
      if (cfg_we) echo_en_r <= cfg_wdata;
      pending_r <= pending_nxt;
      held_a_r  <= held_a_nxt;
      active_r  <= active_nxt;
      discard_r <= discard_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) byte_r <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= line_mem[mem_raddr];
  end

  // Output register
  always_comb begin
    ld_kind = atclr_pkg::KIND_ECHO;
    ld_byte = byte_r;
    case (cmd.out_op)
      atclr_pkg::OUT_ECHO_HELD: ld_byte = held_a_r;
      atclr_pkg::OUT_BS:        ld_byte = atclr_pkg::CH_BS;
      atclr_pkg::OUT_SP:        ld_byte = atclr_pkg::CH_SP;
      atclr_pkg::OUT_REJECT: begin
        ld_kind = atclr_pkg::KIND_REJECT;
        ld_byte = '0;
      end
      atclr_pkg::OUT_CMD: begin
        ld_kind = atclr_pkg::KIND_CMD;
        ld_byte = rdata_r;
      end
      default: ld_byte = byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_op != atclr_pkg::OUT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_op != atclr_pkg::OUT_NONE) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts.cls         = cls;
    sts.echo_en     = echo_en_r;
    sts.active      = active_r;
    sts.discard     = discard_r;
    sts.pending     = pending_r;
    sts.len_zero    = (len_r == '0);
    sts.len_full    = (len_r >= LEN_FULL);
    sts.stream_done = (idx_r == len_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

[design/at_command_line_receiver_core.sv]
// AT command line receiver, top level.
// Depends on atclr_pkg, atclr_in_if, atclr_out_if, atclr_ctrl and atclr_dp.
`default_nettype none

// Takes terminal bytes one item at a time and returns echo bytes, the
// completed command line, or a rejection for an overlong line. Bytes are
// dropped until an A/a is directly followed by T/t; from then on the line
// (AT included) is kept in a LINE_DEPTH-entry byte memory holding at most
// LINE_DEPTH-1 characters. BS and DEL erase one character (echo BS SP BS),
// LF is ignored, CR echoes and then streams the stored line as command
// items, the final one flagged by last_of_run. Every item that produces
// results flags its final result the same way. cfg_wdata on cfg_we sets
// echo (on after reset); write it only while the block is idle.
// Timing: one item is handled at a time. An item is taken in S_IDLE and
// decoded in the next cycle; an item with no result then returns to
// S_IDLE, but a T that opens a line passes through S_STORE_T first. On CR
// the line is read back through the memory's single registered read port,
// S_PREFETCH fetching the first byte. Echo, rejection and command results
// follow at one per cycle while the output is free. The output register
// lets a new item be accepted while the final result still waits; a
// stalled output holds the sequence in place.
module at_command_line_receiver_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  atclr_in_if.sink   in_ch,
  atclr_out_if.source out_ch
);

  atclr_pkg::dp_cmd_t cmd;
  atclr_pkg::dp_sts_t sts;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       in_ready;

  // Sequencing of the results of each item.
  atclr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Line state, line memory and output register.
  atclr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_ch.in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = out_kind;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;

endmodule

`default_nettype wire

[design/atclr_checker.sv]
// Port-level checker for the AT command line receiver, bound to the top.
// Depends on atclr_pkg and at_command_line_receiver_core_macros.svh.
`default_nettype none
`include "at_command_line_receiver_core_macros.svh"

module atclr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  `ATCLR_ASSERT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ATCLR_ASSERT_HOLD(a_out_byte_holds, clk, rst_n, out_valid && !out_ready, out_byte, "stalled byte changed")
  `ATCLR_ASSERT(a_reject_form, clk, rst_n, out_valid && (out_kind == atclr_pkg::KIND_REJECT) |-> (out_byte == 8'h00) && out_last, "rejection not a lone zero item")
  `ATCLR_ASSERT(a_one_item_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "item accepted during decode")

endmodule

bind at_command_line_receiver_core atclr_checker u_atclr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run)
);

`default_nettype wire

[tb/sv/tb_at_command_line_receiver_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for at_command_line_receiver_core: terminal bytes in,
// echo/command/rejection items out. Depends on atclr_pkg, atclr_in_if, atclr_out_if.

module tb_at_command_line_receiver_core;

  localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES   = 40;    // outlasts a full-line CR run
  localparam int ITEMS_PER_PHASE = 80;    // AT...CR line items per idle phase
  localparam int REPORT_MAX      = 10;

  // One result item as the terminal side sees it.
  typedef struct packed {
    atclr_pkg::kind_t kind;
    logic [7:0]       data;
    logic             last;
  } term_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  atclr_in_if  in_ch ();
  atclr_out_if out_ch ();

  at_command_line_receiver_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Line editor state kept by the testbench, mirrors the block's behavior.
  // ---------------------------------------------------------------------------
  logic       echo_on;
  logic       a_waiting;      // A/a seen, waiting for T/t
  logic [7:0] held_a;
  logic       line_open;      // AT confirmed, collecting a command
  logic       discarding;     // overlong line, drop bytes up to CR
  logic [5:0] line_len;
  logic [7:0] line_buf [atclr_pkg::LINE_DEPTH];

  term_result_t run_q[$];         // results of the item being worked out
  term_result_t owed_results[$];  // results the block still has to deliver
  logic [7:0]   send_q[$];        // bytes waiting for the driver

  int items_queued;
  int items_taken;
  int results_seen;
  int lines_seen;
  int rejects_seen;
  int cfg_writes;
  int mismatches;
  int quiet_cycles;
  int src_idle_pct;
  int sink_stall_pct;
  int shaped_items;

  function automatic bit is_erase(logic [7:0] b);
    return (b == atclr_pkg::CH_BS) || (b == atclr_pkg::CH_DEL);
  endfunction

  function automatic void post(atclr_pkg::kind_t k, logic [7:0] d);
    term_result_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    run_q.push_back(r);
  endfunction

  // Erase echoes as BS SP BS; everything else echoes as itself.
  function automatic void echo_char(logic [7:0] b);
    if (echo_on) begin
      if (is_erase(b)) begin
        post(atclr_pkg::KIND_ECHO, atclr_pkg::CH_BS);
        post(atclr_pkg::KIND_ECHO, atclr_pkg::CH_SP);
        post(atclr_pkg::KIND_ECHO, atclr_pkg::CH_BS);
      end else begin
        post(atclr_pkg::KIND_ECHO, b);
      end
    end
  endfunction

  // Works out the results of one accepted byte and queues them in order,
  // the final one flagged.
  function automatic void receive_term_byte(logic [7:0] b);
    term_result_t r;
    run_q.delete();
    if (!line_open) begin
      // hunting for the AT prefix; nothing here is echoed until T lands
      if (b == atclr_pkg::CH_LF || b == atclr_pkg::CH_CR || is_erase(b)) begin
        a_waiting = 1'b0;
      end else if (a_waiting && (b == atclr_pkg::CH_UT || b == atclr_pkg::CH_LT)) begin
        line_buf[0] = held_a;
        line_buf[1] = b;
        line_len    = 6'd2;
        line_open   = 1'b1;
        a_waiting   = 1'b0;
        if (echo_on) begin
          post(atclr_pkg::KIND_ECHO, held_a);
          post(atclr_pkg::KIND_ECHO, b);
        end
      end else if (b == atclr_pkg::CH_UA || b == atclr_pkg::CH_LA) begin
        held_a    = b;
        a_waiting = 1'b1;
      end else begin
        a_waiting = 1'b0;
      end
    end else if (b == atclr_pkg::CH_LF) begin
      // LF inside a line is dropped
    end else if (is_erase(b)) begin
      // ignored while discarding or on an empty line
      if (!discarding && line_len != 0) begin
        line_len = line_len - 6'd1;
        echo_char(b);
        if (line_len == 0) begin
          // erased back past the prefix: AT must be typed again
          line_open = 1'b0;
          a_waiting = 1'b0;
        end
      end
    end else begin
      echo_char(b);
      if (b == atclr_pkg::CH_CR) begin
        if (!discarding) begin
          for (int i = 0; i < line_len; i++) post(atclr_pkg::KIND_CMD, line_buf[i]);
        end
        discarding = 1'b0;
        line_len   = 6'd0;
        line_open  = 1'b0;
        a_waiting  = 1'b0;
      end else if (!discarding) begin
        if (line_len >= atclr_pkg::LINE_DEPTH - 1) begin
          line_len   = 6'd0;
          discarding = 1'b1;
          post(atclr_pkg::KIND_REJECT, 8'h00);
        end else begin
          line_buf[line_len[atclr_pkg::LINE_AW-1:0]] = b;
          line_len = line_len + 6'd1;
        end
      end
    end
    for (int i = 0; i < run_q.size(); i++) begin
      r = run_q[i];
      r.last = (i == run_q.size() - 1);
      owed_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one byte per accepted item, random gaps per src_idle_pct.
  // The model runs on the accepting edge so owed_results and items_taken
  // always move together.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        receive_term_byte(in_ch.in_byte);
        items_taken++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // item not taken yet: hold valid and byte
      end else if (send_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= send_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every accepted result with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.result_kind == atclr_pkg::KIND_REJECT) rejects_seen++;
        if (out_ch.result_kind == atclr_pkg::KIND_CMD && out_ch.last_of_run) lines_seen++;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] unexpected result: kind %0d byte %02h last %0b", $time,
                     out_ch.result_kind, out_ch.out_byte, out_ch.last_of_run);
        end else begin
          term_result_t exp_r;
          exp_r = owed_results.pop_front();
          if (out_ch.result_kind !== exp_r.kind || out_ch.out_byte !== exp_r.data ||
              out_ch.last_of_run !== exp_r.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("[%0t] result mismatch: want kind %0d byte %02h last %0b, got %0d %02h %0b",
                       $time, exp_r.kind, exp_r.data, exp_r.last,
                       out_ch.result_kind, out_ch.out_byte, out_ch.last_of_run);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    send_q.push_back(b);
    items_queued++;
  endfunction

  // Sender holds off until every queued byte is taken and every result is in.
  task automatic wait_line_quiet();
    while (items_taken != items_queued || owed_results.size() != 0) @(posedge clk);
  endtask

  // Echo may only change while the block is idle. Items with no result can
  // still be in flight, so give it a full CR run's worth of cycles too.
  task automatic set_echo(logic v);
    wait_line_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    echo_on    = v;
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // AT line with random body and CR. Long bodies run into the capacity limit,
  // so erases, bytes and CR while discarding come out of these as well.
  task automatic queue_command_line();
    int         body_len;
    logic [7:0] c;
    body_len = ($urandom_range(0, 4) == 0) ? $urandom_range(26, 40) : $urandom_range(0, 12);
    push_byte($urandom_range(0, 1) ? atclr_pkg::CH_UA : atclr_pkg::CH_LA);
    push_byte($urandom_range(0, 1) ? atclr_pkg::CH_UT : atclr_pkg::CH_LT);
    for (int i = 0; i < body_len; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    c = $urandom_range(0, 1) ? atclr_pkg::CH_BS : atclr_pkg::CH_DEL;
        2:       c = atclr_pkg::CH_LF;
        3, 4, 5: c = 8'($urandom_range(0, 255));
        default: c = 8'($urandom_range(8'h21, 8'h7e));
      endcase
      push_byte(c);
    end
    push_byte(atclr_pkg::CH_CR);
    shaped_items += body_len + 3;
  endtask

  // Junk and broken prefixes: lone A, A then non-T, stray controls.
  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       push_byte($urandom_range(0, 1) ? atclr_pkg::CH_UA : atclr_pkg::CH_LA);
        1:       push_byte($urandom_range(0, 1) ? atclr_pkg::CH_UT : atclr_pkg::CH_LT);
        2:       push_byte($urandom_range(0, 1) ? atclr_pkg::CH_CR : atclr_pkg::CH_LF);
        3:       push_byte($urandom_range(0, 1) ? atclr_pkg::CH_BS : atclr_pkg::CH_DEL);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    echo_on        = 1'b1;
    a_waiting      = 1'b0;
    held_a         = 8'h00;
    line_open      = 1'b0;
    discarding     = 1'b0;
    line_len       = 6'd0;
    items_queued   = 0;
    items_taken    = 0;
    results_seen   = 0;
    lines_seen     = 0;
    rejects_seen   = 0;
    cfg_writes     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    shaped_items   = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, echo on from reset, no idling.
    push_byte(8'h00);   // junk before prefix
    push_byte(8'hff);
    push_byte(atclr_pkg::CH_UA);
    push_byte(atclr_pkg::CH_CR);   // control before prefix drops the pending A
    push_byte(atclr_pkg::CH_UT);   // so this T goes nowhere
    push_byte(atclr_pkg::CH_LA);
    push_byte(atclr_pkg::CH_UA);   // repeated A replaces the held letter
    push_byte(atclr_pkg::CH_LT);   // line opens as "At"
    push_byte(8'h80);   // high bytes are plain characters
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(atclr_pkg::CH_LF);   // ignored in a line
    push_byte(atclr_pkg::CH_BS);
    push_byte(atclr_pkg::CH_DEL);
    push_byte(atclr_pkg::CH_CR);   // streams "At" 0x80
    push_byte(atclr_pkg::CH_LA);
    push_byte(atclr_pkg::CH_UT);
    push_byte(atclr_pkg::CH_DEL);
    push_byte(atclr_pkg::CH_BS);   // erased to empty, line closes
    push_byte(atclr_pkg::CH_UT);   // prefix must be retyped: dropped
    push_byte(atclr_pkg::CH_DEL);  // erase before prefix
    push_byte(atclr_pkg::CH_UA);
    push_byte(atclr_pkg::CH_UT);
    push_byte(8'h7e);
    push_byte(atclr_pkg::CH_CR);

    // Random part: four idle mixes, echo toggled between them.
    for (int phase = 0; phase < 4; phase++) begin
      bit paused;
      set_echo(phase[0]);
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      shaped_items = 0;
      paused = 1'b0;
      while (shaped_items < ITEMS_PER_PHASE) begin
        if (!paused && shaped_items >= ITEMS_PER_PHASE / 2) begin
          // hold the sender until the block has delivered everything
          paused = 1'b1;
          wait_line_quiet();
        end
        if ($urandom_range(0, 3) != 0) queue_command_line();
        else queue_noise();
      end
    end

    wait_line_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) mismatches++;

    $display("Sent %0d terminal bytes, checked %0d results: %0d command lines, %0d rejections.",
             items_taken, results_seen, lines_seen, rejects_seen);
    $display("Echo written %0d times; idle mixes: none, sender, receiver, both.", cfg_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
